// ===== hdl/psd_pkg.sv =====
// Package for the raw PNM stream decoder: parse phases, image kinds,
// error codes and the byte constants of the header syntax. No dependencies.
`default_nettype none
package psd_pkg;

  typedef enum logic [4:0] {
    PH_MAGIC = 5'b00001,
    PH_TYPE  = 5'b00010,
    PH_HEAD  = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  localparam logic [1:0] KIND_BITMAP = 2'd0;
  localparam logic [1:0] KIND_GRAY   = 2'd1;
  localparam logic [1:0] KIND_PIXMAP = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MAGIC  = 2'd1;
  localparam logic [1:0] ERR_TYPE   = 2'd2;
  localparam logic [1:0] ERR_MAXVAL = 2'd3;

  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;

  localparam int         ACC_BITS   = 17;
  localparam logic [16:0] ACC_CAP   = 17'd65536;
  localparam logic [8:0] MAXVAL_CAP = 9'd256;

endpackage
`default_nettype wire

// ===== hdl/pnm_stream_decoder.sv =====
// Raw PNM (P4/P5/P6) stream decoder top level.
// Depends on psd_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one file byte per request, with
//   start_of_file marking the first byte of a file (restarts the parser).
//   Output channel out_valid/out_ready carries one result per request: first
//   a header result (or an error result), then one result per sample.
// Path: a byte is registered in the input register on acceptance, and each
//   result it yields is registered in the output register that drives
//   out_valid.
// Throughput: a new header, graymap or pixmap byte is accepted every cycle
//   unless a result it must emit is held up by out_ready. A bitmap byte stays in the input
//   register until it has yielded all its pixels (up to eight); a '#' that
//   ends the last header number and starts the data stays for the header
//   result and then for its own samples. The result register is the limit:
//   one result per cycle while out_ready is high.
// Reset: rst (synchronous) empties both registers and returns the parser
//   to waiting for the 'P' of the magic.
// Stall: while out_ready is low a full result register holds; a byte that
//   needs to emit a result waits, while a byte that emits none still moves.
`default_nettype none
module pnm_stream_decoder
  import psd_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        start_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             is_header,
  output logic [1:0]       image_kind,
  output logic [15:0]      width,
  output logic [15:0]      height,
  output logic [7:0]       max_value,
  output logic [7:0]       sample,
  output logic [1:0]       channel,
  output logic [1:0]       error_code,
  output logic             last
);

  localparam int SL_BITS = 2 * DIM_BITS + 2;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

  // input register
  logic              a_valid;
  logic [7:0]        a_byte;
  logic              a_sof;
  logic [2:0]        bit_pos;

  // parser state
  phase_t                phase;
  logic [1:0]            kind_reg;
  logic [1:0]            field_number;
  logic [ACC_BITS-1:0]   number_accum;
  logic                  in_digits;
  logic                  in_comment;
  logic [DIM_BITS-1:0]   width_reg;
  logic [DIM_BITS-1:0]   height_reg;
  logic [8:0]            maxval_reg;
  logic [DIM_BITS-1:0]   column_count;
  logic [SL_BITS-1:0]    samples_left;
  logic [1:0]            channel_count;

  // state seen by this step (reset applied for start of file)
  phase_t                e_phase;
  logic [1:0]            e_kind;
  logic [1:0]            e_field;
  logic [ACC_BITS-1:0]   e_acc;
  logic                  e_digits;
  logic                  e_comment;
  logic [DIM_BITS-1:0]   e_width;
  logic [DIM_BITS-1:0]   e_height;
  logic [8:0]            e_maxval;
  logic [DIM_BITS-1:0]   e_column;
  logic [SL_BITS-1:0]    e_samples;
  logic [1:0]            e_channel;

  phase_t                phase_next;
  logic [1:0]            kind_next;
  logic [1:0]            field_next;
  logic [ACC_BITS-1:0]   acc_next;
  logic                  digits_next;
  logic                  comment_next;
  logic [DIM_BITS-1:0]   width_next;
  logic [DIM_BITS-1:0]   height_next;
  logic [8:0]            maxval_next;
  logic [DIM_BITS-1:0]   column_next;
  logic [SL_BITS-1:0]    samples_next;
  logic [1:0]            channel_next;
  logic [2:0]            bit_pos_next;

  // result of this step
  logic                  emit;
  logic                  finish;
  logic                  res_hdr;
  logic [1:0]            res_kind;
  logic [DIM_BITS-1:0]   res_w;
  logic [DIM_BITS-1:0]   res_h;
  logic [7:0]            res_mv;
  logic [7:0]            res_smp;
  logic [1:0]            res_ch;
  logic [1:0]            res_err;
  logic                  res_last;

  // datapath helpers
  logic                  digit;
  logic [7:0]            digit_val;
  logic [20:0]           acc_mul;
  logic [DIM_BITS-1:0]   acc_dim;
  logic [8:0]            acc_mv;
  logic [DIM_BITS-1:0]   hdr_h;
  logic [8:0]            mv_final;
  logic [2*DIM_BITS-1:0] area;
  logic [SL_BITS-1:0]    total;
  logic [SL_BITS-1:0]    sl_dec;
  logic [DIM_BITS-1:0]   col_inc;
  logic                  out_free;
  logic                  step_go;
  logic                  done;

  assign digit     = (a_byte >= CH_0) && (a_byte <= CH_9);
  assign digit_val = a_byte - CH_0;
  assign acc_mul   = {1'b0, e_acc, 3'b000} + {3'b000, e_acc, 1'b0} + {13'd0, digit_val};
  assign acc_dim   = (e_acc > ACC_BITS'(DIM_MAX)) ? DIM_MAX : e_acc[DIM_BITS-1:0];
  assign acc_mv    = (e_acc >= ACC_BITS'(MAXVAL_CAP)) ? MAXVAL_CAP : e_acc[8:0];
  assign hdr_h     = (e_field == 2'd1) ? acc_dim : e_height;
  assign mv_final  = (e_kind == KIND_BITMAP) ? 9'd1 : acc_mv;
  assign area      = e_width * hdr_h;
  assign total     = {2'b00, area}
                   + ((e_kind == KIND_PIXMAP) ? {1'b0, area, 1'b0} : '0);
  assign sl_dec    = e_samples - SL_BITS'(1);
  assign col_inc   = e_column + DIM_BITS'(1);

  always_comb begin
    e_phase   = a_sof ? PH_MAGIC : phase;
    e_kind    = a_sof ? 2'd0 : kind_reg;
    e_field   = a_sof ? 2'd0 : field_number;
    e_acc     = a_sof ? '0 : number_accum;
    e_digits  = a_sof ? 1'b0 : in_digits;
    e_comment = a_sof ? 1'b0 : in_comment;
    e_width   = a_sof ? '0 : width_reg;
    e_height  = a_sof ? '0 : height_reg;
    e_maxval  = a_sof ? '0 : maxval_reg;
    e_column  = a_sof ? '0 : column_count;
    e_samples = a_sof ? '0 : samples_left;
    e_channel = a_sof ? 2'd0 : channel_count;

    phase_next   = e_phase;
    kind_next    = e_kind;
    field_next   = e_field;
    acc_next     = e_acc;
    digits_next  = e_digits;
    comment_next = e_comment;
    width_next   = e_width;
    height_next  = e_height;
    maxval_next  = e_maxval;
    column_next  = e_column;
    samples_next = e_samples;
    channel_next = e_channel;
    bit_pos_next = bit_pos - 3'd1;

    emit     = 1'b0;
    finish   = 1'b1;
    res_hdr  = 1'b1;
    res_kind = KIND_BITMAP;
    res_w    = '0;
    res_h    = '0;
    res_mv   = '0;
    res_smp  = '0;
    res_ch   = 2'd0;
    res_err  = ERR_NONE;
    res_last = 1'b1;

    unique case (e_phase)
      PH_MAGIC: begin
        if (a_byte == CH_P) begin
          phase_next = PH_TYPE;
        end else begin
          emit       = 1'b1;
          res_err    = ERR_MAGIC;
          phase_next = PH_DONE;
        end
      end
      PH_TYPE: begin
        if (a_byte >= CH_4 && a_byte <= CH_6) begin
          kind_next  = 2'(a_byte - CH_4);
          phase_next = PH_HEAD;
        end else begin
          emit       = 1'b1;
          res_err    = ERR_TYPE;
          phase_next = PH_DONE;
        end
      end
      PH_HEAD: begin
        if (e_comment) begin
          if (a_byte == CH_LF) comment_next = 1'b0;
        end else if (e_digits) begin
          if (digit) begin
            acc_next = (acc_mul > 21'(ACC_CAP)) ? ACC_CAP : acc_mul[ACC_BITS-1:0];
          end else begin
            // number ends here
            digits_next = 1'b0;
            case (e_field)
              2'd0:    width_next  = acc_dim;
              2'd1:    height_next = acc_dim;
              default: maxval_next = acc_mv;
            endcase
            if (e_field < ((e_kind == KIND_BITMAP) ? 2'd1 : 2'd2)) begin
              field_next = e_field + 2'd1;
              if (a_byte == CH_HASH) comment_next = 1'b1;
            end else begin
              maxval_next = mv_final;
              emit        = 1'b1;
              res_kind    = e_kind;
              res_w       = e_width;
              res_h       = hdr_h;
              if (mv_final >= MAXVAL_CAP) begin
                res_err    = ERR_MAXVAL;
                phase_next = PH_DONE;
              end else begin
                res_mv       = mv_final[7:0];
                res_last     = (total == '0);
                samples_next = total;
                column_next  = '0;
                channel_next = 2'd0;
                if (total == '0) begin
                  phase_next = PH_DONE;
                end else begin
                  phase_next   = PH_DATA;
                  // a '#' here is already the first data byte, from its MSB
                  finish       = (a_byte != CH_HASH);
                  bit_pos_next = bit_pos;
                end
              end
            end
          end
        end else if (digit) begin
          digits_next = 1'b1;
          acc_next    = ACC_BITS'(digit_val);
        end else if (a_byte == CH_HASH) begin
          comment_next = 1'b1;
        end
      end
      PH_DATA: begin
        res_hdr  = 1'b0;
        res_kind = e_kind;
        res_w    = e_width;
        res_h    = e_height;
        res_mv   = e_maxval[7:0];
        res_last = (sl_dec == '0);
        if (e_kind == KIND_BITMAP) begin
          if (e_samples != '0 && e_column < e_width) begin
            emit         = 1'b1;
            res_smp      = {7'd0, a_byte[bit_pos]};
            samples_next = sl_dec;
            finish       = (bit_pos == 3'd0) || (sl_dec == '0) || (col_inc >= e_width);
            column_next  = (finish && col_inc >= e_width) ? '0 : col_inc;
            if (sl_dec == '0) phase_next = PH_DONE;
          end else begin
            if (e_column >= e_width) column_next = '0;
            if (e_samples == '0) phase_next = PH_DONE;
          end
        end else begin
          emit         = 1'b1;
          res_smp      = a_byte;
          samples_next = sl_dec;
          if (e_kind == KIND_PIXMAP) begin
            res_ch       = e_channel;
            channel_next = (e_channel >= 2'd2) ? 2'd0 : e_channel + 2'd1;
          end
          if (sl_dec == '0) phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign step_go  = a_valid && (!emit || out_free);
  assign done     = step_go && finish;
  assign in_ready = !a_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      a_sof         <= 1'b0;
      bit_pos       <= 3'd7;
      out_valid     <= 1'b0;
      phase         <= PH_MAGIC;
      kind_reg      <= 2'd0;
      field_number  <= 2'd0;
      number_accum  <= '0;
      in_digits     <= 1'b0;
      in_comment    <= 1'b0;
      width_reg     <= '0;
      height_reg    <= '0;
      maxval_reg    <= '0;
      column_count  <= '0;
      samples_left  <= '0;
      channel_count <= 2'd0;
    end else begin
      if (step_go) begin
        phase         <= phase_next;
        kind_reg      <= kind_next;
        field_number  <= field_next;
        number_accum  <= acc_next;
        in_digits     <= digits_next;
        in_comment    <= comment_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        maxval_reg    <= maxval_next;
        column_count  <= column_next;
        samples_left  <= samples_next;
        channel_count <= channel_next;
        if (!finish) begin
          a_sof   <= 1'b0;
          bit_pos <= bit_pos_next;
        end
      end
      if (in_valid && in_ready) begin
        a_valid <= 1'b1;
        a_sof   <= start_of_file;
        bit_pos <= 3'd7;
      end else if (done) begin
        a_valid <= 1'b0;
      end
      if (step_go && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= in_byte;
    end
    if (step_go && emit) begin
      is_header  <= res_hdr;
      image_kind <= res_kind;
      width      <= 16'(res_w);
      height     <= 16'(res_h);
      max_value  <= res_mv;
      sample     <= res_smp;
      channel    <= res_ch;
      error_code <= res_err;
      last       <= res_last;
    end
  end

endmodule
`default_nettype wire
